FILE: rtl/core/cau_pkg.sv
// Shared constants, types and helper functions for the complex arithmetic unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cau_pkg;

   // Operand word: signed fixed point, FRAC_BITS fraction bits
   localparam int WORD_BITS   = 32;
   localparam int FRAC_BITS   = 28;
   localparam int INT_BITS    = WORD_BITS - FRAC_BITS;
   localparam int OP_BITS     = 4;
   localparam int EPS_BITS    = 31;
   localparam int STATUS_BITS = 2;
   localparam int PROD_BITS   = 2 * WORD_BITS;
   localparam int SUM_BITS    = PROD_BITS + 2;
   localparam int QUO_BITS    = WORD_BITS + 1;

   localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(1);

   // Operation codes
   localparam logic [OP_BITS-1:0] OP_ADD   = OP_BITS'(0);
   localparam logic [OP_BITS-1:0] OP_SUB   = OP_BITS'(1);
   localparam logic [OP_BITS-1:0] OP_MUL   = OP_BITS'(2);
   localparam logic [OP_BITS-1:0] OP_DIV   = OP_BITS'(3);
   localparam logic [OP_BITS-1:0] OP_ABS   = OP_BITS'(4);
   localparam logic [OP_BITS-1:0] OP_NEG   = OP_BITS'(5);
   localparam logic [OP_BITS-1:0] OP_CONJ  = OP_BITS'(6);
   localparam logic [OP_BITS-1:0] OP_SQMAG = OP_BITS'(7);
   localparam logic [OP_BITS-1:0] OP_EQUAL = OP_BITS'(8);
   localparam logic [OP_BITS-1:0] OP_CLOSE = OP_BITS'(9);

   // Status codes
   localparam logic [STATUS_BITS-1:0] ST_OK   = STATUS_BITS'(0);
   localparam logic [STATUS_BITS-1:0] ST_SAT  = STATUS_BITS'(1);
   localparam logic [STATUS_BITS-1:0] ST_DIV0 = STATUS_BITS'(2);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [WORD_BITS:0]   wext_type;
   typedef logic [PROD_BITS-1:0] prod_type;
   typedef logic [PROD_BITS:0]   wide_type;
   typedef logic [SUM_BITS-1:0]  sum_type;
   typedef logic [QUO_BITS-1:0]  quo_type;

   localparam word_type WORD_MIN = word_type'(1) << (WORD_BITS - 1);
   localparam word_type WORD_MAX = ~WORD_MIN;

   // One word moving through the divide / root stages
   typedef struct packed {
      logic [OP_BITS-1:0] op;
      word_type           fix_re;
      word_type           fix_im;
      logic               fix_sat;
      logic               hit;
      logic               div0;
      logic               neg_re;
      logic               neg_im;
      prod_type           num_re;
      prod_type           num_im;
      prod_type           rem_re;
      prod_type           rem_im;
      quo_type            quo_re;
      quo_type            quo_im;
      logic               ovf_re;
      logic               ovf_im;
      prod_type           den;
      prod_type           sq_s;
      prod_type           sq_res;
   } ds_type;

   typedef struct packed {
      word_type                 re;
      word_type                 im;
      logic                     hit;
      logic [STATUS_BITS-1:0]   status;
   } res_type;

   // Saturate a one-bit-wider signed value to a word; MSB of result flags saturation
   function automatic logic [WORD_BITS:0] sat_word(input wext_type v);
      logic     sat;
      word_type w;
      sat = v[WORD_BITS] ^ v[WORD_BITS-1];
      w   = sat ? (v[WORD_BITS] ? WORD_MIN : WORD_MAX) : v[WORD_BITS-1:0];
      return {sat, w};
   endfunction

   // Turn sign and magnitude into a saturated word; MSB of result flags saturation
   function automatic logic [WORD_BITS:0] pack_signed(input logic neg, input wide_type mag);
      wide_type lim;
      logic     sat;
      word_type m;
      lim = neg ? wide_type'(WORD_MIN) : wide_type'(WORD_MAX);
      sat = mag > lim;
      m   = sat ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
      return {sat, (neg ? (word_type'(0) - m) : m)};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cau_front.sv
// Front pipeline of the complex arithmetic unit: decode, simple ops, products,
// sums, rounding and divider setup in five register stages. Uses cau_pkg.
`default_nettype none

module cau_front (
   input  var logic                         clock,
   input  var logic                         reset,
   input  var logic                         en,
   input  var logic                         in_valid,
   input  var logic [cau_pkg::OP_BITS-1:0]  in_op,
   input  var cau_pkg::word_type            in_a_re,
   input  var cau_pkg::word_type            in_a_im,
   input  var cau_pkg::word_type            in_b_re,
   input  var cau_pkg::word_type            in_b_im,
   input  var logic [cau_pkg::EPS_BITS-1:0] eps,
   output logic                             out_valid,
   output cau_pkg::ds_type                  out_stage
);
   import cau_pkg::*;

   localparam wide_type HALF = wide_type'(1) << (FRAC_BITS - 1);

   // stage 1: magnitudes
   logic               f1_valid_ff;
   logic [OP_BITS-1:0] f1_op_ff;
   word_type           f1_a_re_ff, f1_a_im_ff, f1_b_re_ff, f1_b_im_ff;
   word_type           f1_am_re_ff, f1_am_im_ff, f1_bm_re_ff, f1_bm_im_ff;
   logic               f1_dz_ff;

   // stage 2: products and simple ops
   logic               f2_valid_ff;
   logic [OP_BITS-1:0] f2_op_ff;
   prod_type           f2_p0_ff, f2_p1_ff, f2_p2_ff, f2_p3_ff, f2_p4_ff, f2_p5_ff;
   logic               f2_s0_ff, f2_s1_ff, f2_s2_ff, f2_s3_ff;
   word_type           f2_fix_re_ff, f2_fix_im_ff;
   logic               f2_sat_ff, f2_eq_ff, f2_dz_ff;
   wext_type           f2_d_re_ff, f2_d_im_ff;
   word_type           f2_fix_re_in, f2_fix_im_in;
   logic               f2_sat_in;

   // stage 3: signed sums
   logic               f3_valid_ff;
   logic [OP_BITS-1:0] f3_op_ff;
   sum_type            f3_v_re_ff, f3_v_im_ff;
   prod_type           f3_sq_ff;
   word_type           f3_fix_re_ff, f3_fix_im_ff;
   logic               f3_sat_ff, f3_hit_ff, f3_dz_ff;
   sum_type            f3_v_re_in, f3_v_im_in;
   logic               f3_hit_in;

   // stage 4: sign and magnitude
   logic               f4_valid_ff;
   logic [OP_BITS-1:0] f4_op_ff;
   logic               f4_n_re_ff, f4_n_im_ff;
   prod_type           f4_m_re_ff, f4_m_im_ff, f4_den_ff;
   word_type           f4_fix_re_ff, f4_fix_im_ff;
   logic               f4_sat_ff, f4_hit_ff, f4_dz_ff;

   // stage 5 (output)
   logic               f5_valid_ff;
   ds_type             f5_ff, f5_in;

   // ---- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_op_ff    <= in_op;
         f1_a_re_ff  <= in_a_re;
         f1_a_im_ff  <= in_a_im;
         f1_b_re_ff  <= in_b_re;
         f1_b_im_ff  <= in_b_im;
         f1_am_re_ff <= in_a_re[WORD_BITS-1] ? (word_type'(0) - in_a_re) : in_a_re;
         f1_am_im_ff <= in_a_im[WORD_BITS-1] ? (word_type'(0) - in_a_im) : in_a_im;
         f1_bm_re_ff <= in_b_re[WORD_BITS-1] ? (word_type'(0) - in_b_re) : in_b_re;
         f1_bm_im_ff <= in_b_im[WORD_BITS-1] ? (word_type'(0) - in_b_im) : in_b_im;
         f1_dz_ff    <= (in_b_re == word_type'(0)) && (in_b_im == word_type'(0));
      end
   end

   // ---- stage 2
   logic     f2_sq;
   wext_type xa_re, xa_im, xb_re, xb_im;
   logic [WORD_BITS:0] r_re, r_im;

   always_comb begin
      xa_re = {f1_a_re_ff[WORD_BITS-1], f1_a_re_ff};
      xa_im = {f1_a_im_ff[WORD_BITS-1], f1_a_im_ff};
      xb_re = {f1_b_re_ff[WORD_BITS-1], f1_b_re_ff};
      xb_im = {f1_b_im_ff[WORD_BITS-1], f1_b_im_ff};
      f2_fix_re_in = '0;
      f2_fix_im_in = '0;
      f2_sat_in    = 1'b0;
      r_re = '0;
      r_im = '0;
      case (f1_op_ff)
         OP_ADD: begin
            r_re = sat_word(xa_re + xb_re);
            r_im = sat_word(xa_im + xb_im);
         end
         OP_SUB: begin
            r_re = sat_word(xa_re - xb_re);
            r_im = sat_word(xa_im - xb_im);
         end
         OP_NEG: begin
            r_re = sat_word(wext_type'(0) - xa_re);
            r_im = sat_word(wext_type'(0) - xa_im);
         end
         OP_CONJ: begin
            r_re = {1'b0, f1_a_re_ff};
            r_im = sat_word(wext_type'(0) - xa_im);
         end
         default: begin
            r_re = '0;
            r_im = '0;
         end
      endcase
      f2_fix_re_in = r_re[WORD_BITS-1:0];
      f2_fix_im_in = r_im[WORD_BITS-1:0];
      f2_sat_in    = r_re[WORD_BITS] | r_im[WORD_BITS];
   end

   assign f2_sq = (f1_op_ff == OP_ABS) || (f1_op_ff == OP_SQMAG);

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else if (en) begin
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f2_op_ff     <= f1_op_ff;
         f2_p0_ff     <= prod_type'(f1_am_re_ff) * prod_type'(f1_bm_re_ff);
         f2_p1_ff     <= prod_type'(f1_am_im_ff) * prod_type'(f1_bm_im_ff);
         f2_p2_ff     <= prod_type'(f1_am_re_ff) * prod_type'(f1_bm_im_ff);
         f2_p3_ff     <= prod_type'(f1_am_im_ff) * prod_type'(f1_bm_re_ff);
         f2_p4_ff     <= f2_sq ? prod_type'(f1_am_re_ff) * prod_type'(f1_am_re_ff)
                               : prod_type'(f1_bm_re_ff) * prod_type'(f1_bm_re_ff);
         f2_p5_ff     <= f2_sq ? prod_type'(f1_am_im_ff) * prod_type'(f1_am_im_ff)
                               : prod_type'(f1_bm_im_ff) * prod_type'(f1_bm_im_ff);
         f2_s0_ff     <= f1_a_re_ff[WORD_BITS-1] ^ f1_b_re_ff[WORD_BITS-1];
         f2_s1_ff     <= f1_a_im_ff[WORD_BITS-1] ^ f1_b_im_ff[WORD_BITS-1];
         f2_s2_ff     <= f1_a_re_ff[WORD_BITS-1] ^ f1_b_im_ff[WORD_BITS-1];
         f2_s3_ff     <= f1_a_im_ff[WORD_BITS-1] ^ f1_b_re_ff[WORD_BITS-1];
         f2_fix_re_ff <= f2_fix_re_in;
         f2_fix_im_ff <= f2_fix_im_in;
         f2_sat_ff    <= f2_sat_in;
         f2_eq_ff     <= (f1_a_re_ff == f1_b_re_ff) && (f1_a_im_ff == f1_b_im_ff);
         f2_d_re_ff   <= xa_re - xb_re;
         f2_d_im_ff   <= xa_im - xb_im;
         f2_dz_ff     <= f1_dz_ff;
      end
   end

   // ---- stage 3
   sum_type  sp0, sp1, sp2, sp3;
   wext_type ad_re, ad_im;

   always_comb begin
      sp0 = f2_s0_ff ? (sum_type'(0) - sum_type'(f2_p0_ff)) : sum_type'(f2_p0_ff);
      sp1 = f2_s1_ff ? (sum_type'(0) - sum_type'(f2_p1_ff)) : sum_type'(f2_p1_ff);
      sp2 = f2_s2_ff ? (sum_type'(0) - sum_type'(f2_p2_ff)) : sum_type'(f2_p2_ff);
      sp3 = f2_s3_ff ? (sum_type'(0) - sum_type'(f2_p3_ff)) : sum_type'(f2_p3_ff);
      if (f2_op_ff == OP_MUL) begin
         f3_v_re_in = sp0 - sp1;
         f3_v_im_in = sp2 + sp3;
      end else begin
         f3_v_re_in = sp0 + sp1;
         f3_v_im_in = sp3 - sp2;
      end
      ad_re = f2_d_re_ff[WORD_BITS] ? (wext_type'(0) - f2_d_re_ff) : f2_d_re_ff;
      ad_im = f2_d_im_ff[WORD_BITS] ? (wext_type'(0) - f2_d_im_ff) : f2_d_im_ff;
      case (f2_op_ff)
         OP_EQUAL: f3_hit_in = f2_eq_ff;
         OP_CLOSE: f3_hit_in = (ad_re < wext_type'(eps)) && (ad_im < wext_type'(eps));
         default:  f3_hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_valid_ff <= 1'b0;
      end else if (en) begin
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f3_op_ff     <= f2_op_ff;
         f3_v_re_ff   <= f3_v_re_in;
         f3_v_im_ff   <= f3_v_im_in;
         f3_sq_ff     <= f2_p4_ff + f2_p5_ff;
         f3_fix_re_ff <= f2_fix_re_ff;
         f3_fix_im_ff <= f2_fix_im_ff;
         f3_sat_ff    <= f2_sat_ff;
         f3_hit_ff    <= f3_hit_in;
         f3_dz_ff     <= f2_dz_ff;
      end
   end

   // ---- stage 4
   sum_type av_re, av_im;
   logic    f4_sq;

   always_comb begin
      av_re = f3_v_re_ff[SUM_BITS-1] ? (sum_type'(0) - f3_v_re_ff) : f3_v_re_ff;
      av_im = f3_v_im_ff[SUM_BITS-1] ? (sum_type'(0) - f3_v_im_ff) : f3_v_im_ff;
      f4_sq = (f3_op_ff == OP_ABS) || (f3_op_ff == OP_SQMAG);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f4_valid_ff <= 1'b0;
      end else if (en) begin
         f4_valid_ff <= f3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f4_op_ff     <= f3_op_ff;
         f4_n_re_ff   <= f4_sq ? 1'b0 : f3_v_re_ff[SUM_BITS-1];
         f4_n_im_ff   <= f4_sq ? 1'b0 : f3_v_im_ff[SUM_BITS-1];
         f4_m_re_ff   <= f4_sq ? f3_sq_ff : av_re[PROD_BITS-1:0];
         f4_m_im_ff   <= f4_sq ? prod_type'(0) : av_im[PROD_BITS-1:0];
         f4_den_ff    <= f3_sq_ff;
         f4_fix_re_ff <= f3_fix_re_ff;
         f4_fix_im_ff <= f3_fix_im_ff;
         f4_sat_ff    <= f3_sat_ff;
         f4_hit_ff    <= f3_hit_ff;
         f4_dz_ff     <= f3_dz_ff;
      end
   end

   // ---- stage 5: round products, set up divider and root
   wide_type           rnd_re, rnd_im;
   logic [WORD_BITS:0] pk_re, pk_im;
   prod_type           init_re, init_im;

   always_comb begin
      rnd_re  = (wide_type'(f4_m_re_ff) + HALF) >> FRAC_BITS;
      rnd_im  = (wide_type'(f4_m_im_ff) + HALF) >> FRAC_BITS;
      pk_re   = pack_signed(f4_n_re_ff && (rnd_re != wide_type'(0)), rnd_re);
      pk_im   = pack_signed(f4_n_im_ff && (rnd_im != wide_type'(0)), rnd_im);
      init_re = f4_m_re_ff >> INT_BITS;
      init_im = f4_m_im_ff >> INT_BITS;

      f5_in         = '0;
      f5_in.op      = f4_op_ff;
      f5_in.fix_re  = f4_fix_re_ff;
      f5_in.fix_im  = f4_fix_im_ff;
      f5_in.fix_sat = f4_sat_ff;
      f5_in.hit     = f4_hit_ff;
      f5_in.div0    = f4_dz_ff && (f4_op_ff == OP_DIV);
      f5_in.neg_re  = f4_n_re_ff;
      f5_in.neg_im  = f4_n_im_ff;
      f5_in.num_re  = f4_m_re_ff;
      f5_in.num_im  = f4_m_im_ff;
      f5_in.rem_re  = init_re;
      f5_in.rem_im  = init_im;
      f5_in.quo_re  = '0;
      f5_in.quo_im  = '0;
      f5_in.ovf_re  = init_re >= f4_den_ff;
      f5_in.ovf_im  = init_im >= f4_den_ff;
      f5_in.den     = f4_den_ff;
      f5_in.sq_s    = f4_den_ff;
      f5_in.sq_res  = '0;
      case (f4_op_ff)
         OP_MUL: begin
            f5_in.fix_re  = pk_re[WORD_BITS-1:0];
            f5_in.fix_im  = pk_im[WORD_BITS-1:0];
            f5_in.fix_sat = pk_re[WORD_BITS] | pk_im[WORD_BITS];
         end
         OP_SQMAG: begin
            f5_in.fix_re  = pk_re[WORD_BITS-1:0];
            f5_in.fix_im  = '0;
            f5_in.fix_sat = pk_re[WORD_BITS];
         end
         default: begin
            f5_in.fix_sat = f4_sat_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f5_valid_ff <= 1'b0;
      end else if (en) begin
         f5_valid_ff <= f4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f5_ff <= f5_in;
      end
   end

   assign out_valid = f5_valid_ff;
   assign out_stage = f5_ff;

endmodule

`default_nettype wire

FILE: rtl/core/cau_divsqrt.sv
// Pipelined restoring divider (two lanes) and digit-by-digit square root,
// one quotient bit per register stage, one root bit in all but the last. Uses cau_pkg.
`default_nettype none

module cau_divsqrt (
   input  var logic            clock,
   input  var logic            reset,
   input  var logic            en,
   input  var logic            in_valid,
   input  var cau_pkg::ds_type in_stage,
   output logic                out_valid,
   output cau_pkg::ds_type     out_stage
);
   import cau_pkg::*;

   ds_type              pipe_ff [QUO_BITS];
   logic [QUO_BITS-1:0] valid_ff;

   for (genvar j = 0; j < QUO_BITS; j++) begin : g_step
      ds_type   src, nxt;
      wide_type trial_re, trial_im;
      logic     ge_re, ge_im, bit_re, bit_im;
      prod_type sq_s_nx, sq_res_nx;

      if (j == 0) begin : g_first
         assign src = in_stage;
      end else begin : g_next
         assign src = pipe_ff[j-1];
      end

      // shift in the dividend bits, then zeros for the fraction
      if (INT_BITS - 1 - j >= 0) begin : g_bit
         assign bit_re = src.num_re[INT_BITS-1-j];
         assign bit_im = src.num_im[INT_BITS-1-j];
      end else begin : g_zero
         assign bit_re = 1'b0;
         assign bit_im = 1'b0;
      end

      if (j < WORD_BITS) begin : g_root
         localparam prod_type ROOT_BIT = prod_type'(1) << (2 * (WORD_BITS - 1 - j));
         prod_type t;
         logic     fits;
         always_comb begin
            t         = src.sq_res + ROOT_BIT;
            fits      = src.sq_s >= t;
            sq_s_nx   = fits ? (src.sq_s - t) : src.sq_s;
            sq_res_nx = fits ? ((src.sq_res >> 1) + ROOT_BIT) : (src.sq_res >> 1);
         end
      end else begin : g_root_idle
         assign sq_s_nx   = src.sq_s;
         assign sq_res_nx = src.sq_res;
      end

      always_comb begin
         trial_re   = {src.rem_re, bit_re};
         trial_im   = {src.rem_im, bit_im};
         ge_re      = trial_re >= {1'b0, src.den};
         ge_im      = trial_im >= {1'b0, src.den};
         nxt        = src;
         nxt.rem_re = ge_re ? prod_type'(trial_re - {1'b0, src.den}) : trial_re[PROD_BITS-1:0];
         nxt.rem_im = ge_im ? prod_type'(trial_im - {1'b0, src.den}) : trial_im[PROD_BITS-1:0];
         nxt.quo_re = {src.quo_re[QUO_BITS-2:0], ge_re};
         nxt.quo_im = {src.quo_im[QUO_BITS-2:0], ge_im};
         nxt.sq_s   = sq_s_nx;
         nxt.sq_res = sq_res_nx;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pipe_ff[j] <= nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QUO_BITS-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[QUO_BITS-1];
   assign out_stage = pipe_ff[QUO_BITS-1];

endmodule

`default_nettype wire

FILE: rtl/core/cau_finish.sv
// Result assembly: rounds quotient and root, saturates, picks the result of
// the operation and forms the status code. Uses cau_pkg.
`default_nettype none

module cau_finish (
   input  var cau_pkg::ds_type in_stage,
   output cau_pkg::res_type    result
);
   import cau_pkg::*;

   wide_type           q_re, q_im, root;
   logic [WORD_BITS:0] pk_re, pk_im, pk_root;
   logic               sat;

   always_comb begin
      // drop the extra quotient bit with round half away from zero
      q_re    = (wide_type'(in_stage.quo_re) + wide_type'(1)) >> 1;
      q_im    = (wide_type'(in_stage.quo_im) + wide_type'(1)) >> 1;
      pk_re   = in_stage.ovf_re ? pack_signed(in_stage.neg_re, '1)
                                : pack_signed(in_stage.neg_re && (q_re != wide_type'(0)), q_re);
      pk_im   = in_stage.ovf_im ? pack_signed(in_stage.neg_im, '1)
                                : pack_signed(in_stage.neg_im && (q_im != wide_type'(0)), q_im);
      root    = wide_type'(in_stage.sq_res) +
                ((in_stage.sq_s > in_stage.sq_res) ? wide_type'(1) : wide_type'(0));
      pk_root = pack_signed(1'b0, root);

      result     = '0;
      result.hit = in_stage.hit;
      sat        = in_stage.fix_sat;
      case (in_stage.op)
         OP_DIV: begin
            result.re = pk_re[WORD_BITS-1:0];
            result.im = pk_im[WORD_BITS-1:0];
            sat       = pk_re[WORD_BITS] | pk_im[WORD_BITS];
         end
         OP_ABS: begin
            result.re = pk_root[WORD_BITS-1:0];
            result.im = '0;
            sat       = pk_root[WORD_BITS];
         end
         default: begin
            result.re = in_stage.fix_re;
            result.im = in_stage.fix_im;
         end
      endcase

      if (in_stage.div0) begin
         result.re     = '0;
         result.im     = '0;
         result.status = ST_DIV0;
      end else if (sat) begin
         result.status = ST_SAT;
      end else begin
         result.status = ST_OK;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front pipeline, divide/root
// stages, result assembly and output skid buffer. Uses cau_pkg and submodules.
//
// Usage:
//   req_* carries one word per item: two complex operands in Q4.28 and an
//   operation code (add, sub, mul, div, abs, neg, conj, sqmag, equal, close).
//   rsp_* returns one word per item, in order: the saturated complex result,
//   the compare flag and a status code (ok, saturated, division by zero).
//   csr_wr_en writes the closeness epsilon; write it only while idle.
// Path: the word passes 5 front stages, 33 divider stages of one quotient bit
//   each and one output register, 39 registers in all, the first loaded at the
//   accepting edge.
// Throughput: one item per cycle unless stalled; every op follows the same path.
// Reset: synchronous; clears all valid bits, the skid buffer's included, and
//   sets epsilon to 1.
// Stall: while rsp_tready is low the output word holds and one more word
//   lands in the spare register; only then does the whole pipeline freeze
//   and req_tready drop. No word is lost or repeated.
`default_nettype none

module complex_arithmetic_unit (
   input  var logic                               clock,
   input  var logic                               reset,
   input  var logic                               req_tvalid,
   output logic                                   req_tready,
   // a_re, a_im, b_re, b_im
   input  var logic [4*cau_pkg::WORD_BITS-1:0]    req_tdata,
   // operation
   input  var logic [cau_pkg::OP_BITS-1:0]        req_tuser,
   output logic                                   rsp_tvalid,
   input  var logic                               rsp_tready,
   // res_re, res_im
   output logic [2*cau_pkg::WORD_BITS-1:0]        rsp_tdata,
   // compare_true, status
   output logic [cau_pkg::STATUS_BITS:0]          rsp_tuser,
   input  var logic                               csr_wr_en,
   input  var logic [cau_pkg::EPS_BITS-1:0]       csr_wr_data
);
   import cau_pkg::*;

   logic [EPS_BITS-1:0] eps_ff, eps_in;
   logic                en;
   logic                front_valid, ds_valid;
   ds_type              front_stage, ds_stage;
   res_type             fin;

   // skid buffer: main output word and one spare
   logic    out_valid_ff, out_valid_in;
   logic    spare_valid_ff, spare_valid_in;
   res_type out_ff, spare_ff;
   logic    take, load_out, load_spare, from_spare;

   // epsilon register
   assign eps_in = csr_wr_en ? csr_wr_data : eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else begin
         eps_ff <= eps_in;
      end
   end

   // advance the pipeline whenever the spare slot is free
   assign en         = !spare_valid_ff;
   assign req_tready = en;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_op     (req_tuser),
      .in_a_re   (req_tdata[WORD_BITS-1:0]),
      .in_a_im   (req_tdata[2*WORD_BITS-1:WORD_BITS]),
      .in_b_re   (req_tdata[3*WORD_BITS-1:2*WORD_BITS]),
      .in_b_im   (req_tdata[4*WORD_BITS-1:3*WORD_BITS]),
      .eps       (eps_ff),
      .out_valid (front_valid),
      .out_stage (front_stage)
   );

   cau_divsqrt u_divsqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_stage  (front_stage),
      .out_valid (ds_valid),
      .out_stage (ds_stage)
   );

   cau_finish u_finish (
      .in_stage (ds_stage),
      .result   (fin)
   );

   // skid control
   always_comb begin
      take           = out_valid_ff && rsp_tready;
      load_out       = 1'b0;
      load_spare     = 1'b0;
      from_spare     = 1'b0;
      out_valid_in   = out_valid_ff;
      spare_valid_in = spare_valid_ff;
      if (spare_valid_ff) begin
         // pipeline frozen: drain the spare first
         if (take) begin
            from_spare     = 1'b1;
            load_out       = 1'b1;
            out_valid_in   = 1'b1;
            spare_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         load_out     = ds_valid;
         out_valid_in = ds_valid;
      end else if (ds_valid) begin
         load_spare     = 1'b1;
         spare_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_ff <= from_spare ? spare_ff : fin;
      end
      if (load_spare) begin
         spare_ff <= fin;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.im, out_ff.re};
   assign rsp_tuser  = {out_ff.status, out_ff.hit};

endmodule

`default_nettype wire

FILE: verif/tb_complex_arithmetic_unit.sv
// Self-checking testbench for complex_arithmetic_unit: directed table, then random words,
// checked against typed row results or a behavioral predictor of the fixed-point ops.
// Depends on cau_pkg and the RTL of complex_arithmetic_unit.
`default_nettype none

module tb_complex_arithmetic_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import cau_pkg::*;

   localparam int  LATENCY     = 39;
   localparam int  RANDOM_WORDS = 1800;
   localparam int  HOLD_CYCLES = 3 * LATENCY;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic [OP_BITS-1:0]     op;
      word_type               a_re;
      word_type               a_im;
      word_type               b_re;
      word_type               b_im;
      logic                   typed;   // expected result written in the row
      word_type               x_re;
      word_type               x_im;
      logic                   x_hit;
      logic [STATUS_BITS-1:0] x_status;
   } vec_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [4*WORD_BITS-1:0]        req_tdata = '0;
   logic [OP_BITS-1:0]            req_tuser = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [2*WORD_BITS-1:0]        rsp_tdata;
   logic [STATUS_BITS:0]          rsp_tuser;
   logic                          csr_wr_en = 1'b0;
   logic [EPS_BITS-1:0]           csr_wr_data = '0;

   complex_arithmetic_unit dut (.*);

   always #6 clock = ~clock;

   // predictor copy of the register
   logic [EPS_BITS-1:0] epsilon = EPS_RESET;
   res_type             expected_results[$];
   int                  mismatches = 0;
   logic                timed_out = 1'b0;
   longint              cycle_count = 0;

   // idle rates in percent, and a long receiver hold-off
   int   send_idle = 0;
   int   recv_idle = 0;
   logic hold_rx = 1'b0;
   event start_hold;

   // ---------------------------------------------------------------------
   // Predictor: exact arithmetic in wide signed vectors, then round and clamp
   // ---------------------------------------------------------------------
   typedef logic signed [199:0] big_type;

   // round magnitude at FRAC_BITS, half away from zero
   function automatic big_type round_frac(big_type v);
      big_type m;
      m = (v < 0) ? -v : v;
      m = (m + (big_type'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return (v < 0) ? -m : m;
   endfunction

   function automatic word_type clamp_word(big_type v, ref logic sat);
      big_type lo, hi;
      lo = -(big_type'(1) <<< (WORD_BITS - 1));
      hi = (big_type'(1) <<< (WORD_BITS - 1)) - 1;
      if (v > hi) begin
         sat = 1'b1;
         return WORD_MAX;
      end
      if (v < lo) begin
         sat = 1'b1;
         return WORD_MIN;
      end
      return v[WORD_BITS-1:0];
   endfunction

   // round(num * 2^FRAC / den), sign of num, magnitude rounded half away
   function automatic big_type divide_round(big_type num, big_type den);
      big_type m, q;
      m = (num < 0) ? -num : num;
      q = ((m <<< (FRAC_BITS + 1)) / den + 1) >>> 1;
      return (num < 0) ? -q : q;
   endfunction

   function automatic big_type root_round(big_type s);
      big_type r, bitv;
      r = 0;
      for (int i = 70; i >= 0; i--) begin
         bitv = big_type'(1) <<< i;
         if ((r + bitv) * (r + bitv) <= s)
            r = r + bitv;
      end
      // round to nearest: up when s - r^2 > r
      if (s - r * r > r)
         r = r + 1;
      return r;
   endfunction

   function automatic res_type predict_result(vec_type v);
      res_type r;
      big_type ar, ai, br, bi, vr, vi, den, dr, di;
      logic    sat;
      ar  = big_type'(signed'(v.a_re));
      ai  = big_type'(signed'(v.a_im));
      br  = big_type'(signed'(v.b_re));
      bi  = big_type'(signed'(v.b_im));
      vr  = 0;
      vi  = 0;
      sat = 1'b0;
      r.hit = 1'b0;
      r.status = ST_OK;
      case (v.op)
         OP_ADD: begin
            vr = ar + br;
            vi = ai + bi;
         end
         OP_SUB: begin
            vr = ar - br;
            vi = ai - bi;
         end
         OP_MUL: begin
            vr = round_frac(ar * br - ai * bi);
            vi = round_frac(ar * bi + ai * br);
         end
         OP_DIV: begin
            den = br * br + bi * bi;
            if (den == 0)
               r.status = ST_DIV0;
            else begin
               vr = divide_round(ar * br + ai * bi, den);
               vi = divide_round(ai * br - ar * bi, den);
            end
         end
         OP_ABS:   vr = root_round(ar * ar + ai * ai);
         OP_NEG: begin
            vr = -ar;
            vi = -ai;
         end
         OP_CONJ: begin
            vr = ar;
            vi = -ai;
         end
         OP_SQMAG: vr = round_frac(ar * ar + ai * ai);
         OP_EQUAL: r.hit = (v.a_re == v.b_re) && (v.a_im == v.b_im);
         OP_CLOSE: begin
            dr = ar - br;
            di = ai - bi;
            if (dr < 0) dr = -dr;
            if (di < 0) di = -di;
            r.hit = (dr < big_type'(epsilon)) && (di < big_type'(epsilon));
         end
         default: ;
      endcase
      r.re = clamp_word(vr, sat);
      r.im = clamp_word(vi, sat);
      if (r.status != ST_DIV0 && sat)
         r.status = ST_SAT;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driving: inputs change on the falling edge
   // ---------------------------------------------------------------------
   task automatic send_word(vec_type v);
      res_type e;
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      e = v.typed ? res_type'{re: v.x_re, im: v.x_im, hit: v.x_hit, status: v.x_status}
                  : predict_result(v);
      req_tvalid <= 1'b1;
      req_tuser  <= v.op;
      req_tdata  <= {v.b_im, v.b_re, v.a_im, v.a_re};
      // wait for acceptance at the rising edge
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      expected_results.push_back(e);
      @(negedge clock);
   endtask

   // drain, then let the pipe settle before touching the register
   task automatic write_epsilon(logic [EPS_BITS-1:0] value);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      epsilon = value;
   endtask

   function automatic word_type pick_operand();
      case ($urandom_range(9))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return word_type'(1) << FRAC_BITS;           // one
         4: return word_type'($urandom_range(15)) - 8;   // tiny
         5: return word_type'(signed'($urandom) >>> $urandom_range(16, 4));
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic vec_type random_word();
      vec_type v;
      v.op    = ($urandom_range(19) == 0) ? OP_BITS'($urandom_range(15, 10))
                                          : OP_BITS'($urandom_range(9));
      v.a_re  = pick_operand();
      v.a_im  = pick_operand();
      v.b_re  = pick_operand();
      v.b_im  = pick_operand();
      // compares need near or equal operands to ever hold
      if ((v.op == OP_EQUAL || v.op == OP_CLOSE) && $urandom_range(1)) begin
         v.b_re = v.a_re + word_type'($urandom_range(6)) - 3;
         v.b_im = v.a_im + word_type'($urandom_range(6)) - 3;
         if (v.op == OP_EQUAL && $urandom_range(1)) begin
            v.b_re = v.a_re;
            v.b_im = v.a_im;
         end
      end
      if (v.op == OP_DIV && $urandom_range(15) == 0) begin
         v.b_re = '0;
         v.b_im = '0;
      end
      v.typed = 1'b0;
      return v;
   endfunction

   // directed table; rows with typed = 1 carry their expected result
   localparam word_type ONE = word_type'(1) << FRAC_BITS;
   vec_type directed_words[] = '{
      '{OP_ADD,   '0, '0, '0, '0, 1'b1, '0, '0, 1'b0, ST_OK},
      '{OP_ADD,   WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, 1'b1, WORD_MAX, WORD_MIN, 1'b0, ST_SAT},
      '{OP_SUB,   WORD_MIN, WORD_MAX, ONE, -ONE, 1'b1, WORD_MIN, WORD_MAX, 1'b0, ST_SAT},
      '{OP_MUL,   ONE, ONE, ONE, -ONE, 1'b0, '0, '0, 1'b0, ST_OK},
      '{OP_MUL,   WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX, 1'b0, '0, '0, 1'b0, ST_OK},
      '{OP_DIV,   ONE, ONE, '0, '0, 1'b1, '0, '0, 1'b0, ST_DIV0},
      '{OP_DIV,   WORD_MAX, WORD_MIN, '0, 1, 1'b0, '0, '0, 1'b0, ST_OK},
      '{OP_DIV,   ONE, '0, ONE, ONE, 1'b0, '0, '0, 1'b0, ST_OK},
      '{OP_ABS,   WORD_MIN, WORD_MIN, '0, '0, 1'b0, '0, '0, 1'b0, ST_OK},
      '{OP_ABS,   -ONE, '0, 5, 5, 1'b1, ONE, '0, 1'b0, ST_OK},
      '{OP_NEG,   WORD_MIN, WORD_MAX, '0, '0, 1'b1, WORD_MAX, -WORD_MAX, 1'b0, ST_SAT},
      '{OP_CONJ,  WORD_MAX, WORD_MIN, '0, '0, 1'b1, WORD_MAX, WORD_MAX, 1'b0, ST_SAT},
      '{OP_SQMAG, WORD_MIN, WORD_MAX, '0, '0, 1'b1, WORD_MAX, '0, 1'b0, ST_SAT},
      '{OP_EQUAL, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 1'b1, '0, '0, 1'b1, ST_OK},
      '{OP_EQUAL, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN, 1'b1, '0, '0, 1'b0, ST_OK},
      '{OP_CLOSE, ONE, ONE, ONE, ONE, 1'b1, '0, '0, 1'b1, ST_OK},
      '{OP_CLOSE, ONE, ONE, ONE + 1, ONE, 1'b1, '0, '0, 1'b0, ST_OK},
      '{OP_CLOSE, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MIN, 1'b0, '0, '0, 1'b0, ST_OK},
      '{4'd10,    ONE, ONE, ONE, ONE, 1'b1, '0, '0, 1'b0, ST_OK},
      '{4'd15,    WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, 1'b1, '0, '0, 1'b0, ST_OK}
   };

   // ---------------------------------------------------------------------
   // Receiver: ready changes on the falling edge, results sampled at rise
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (hold_rx)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
   end

   // long hold-off, counted here while the sender keeps offering words
   always begin
      @(start_hold);
      hold_rx <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_rx <= 1'b0;
   end

   always @(posedge clock) begin
      res_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.re     = rsp_tdata[WORD_BITS-1:0];
         got.im     = rsp_tdata[2*WORD_BITS-1:WORD_BITS];
         got.hit    = rsp_tuser[0];
         got.status = rsp_tuser[STATUS_BITS:1];
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word re=%h im=%h hit=%b st=%0d",
                        got.re, got.im, got.hit, got.status);
         end else begin
            want = expected_results.pop_front();
            if (got.re !== want.re || got.im !== want.im ||
                got.hit !== want.hit || got.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp re=%h im=%h hit=%b st=%0d, got re=%h im=%h hit=%b st=%0d",
                           want.re, want.im, want.hit, want.status,
                           got.re, got.im, got.hit, got.status);
            end
         end
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_complex_arithmetic_unit: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int per_phase;
      logic [EPS_BITS-1:0] settings[4];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows at reset epsilon, no idling
      foreach (directed_words[i])
         send_word(directed_words[i]);

      // exercise the register across its range, extremes included
      settings = '{'0, {EPS_BITS{1'b1}}, EPS_BITS'(4), EPS_BITS'($urandom)};
      per_phase = RANDOM_WORDS / 4;
      for (int p = 0; p < 4; p++) begin
         write_epsilon(settings[p]);
         case (p)
            0: begin send_idle = 17; recv_idle = 87; end
            1: begin send_idle = 87; recv_idle = 17; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         // fill the pipe against a stalled receiver
         if (p == 2)
            -> start_hold;
         for (int i = 0; i < per_phase; i++)
            send_word(random_word());
      end
      req_tvalid <= 1'b0;

      while (expected_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      if (mismatches == 0)
         $display("tb_complex_arithmetic_unit: done, clean");
      else
         $display("tb_complex_arithmetic_unit: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/cau_pkg.sv
rtl/core/cau_front.sv
rtl/core/cau_divsqrt.sv
rtl/core/cau_finish.sv
rtl/core/complex_arithmetic_unit.sv
verif/tb_complex_arithmetic_unit.sv
